>>> rtl/core/variable_length_string_stack_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the string stack
// Property wrappers used by the string stack RTL.
// ---------------------------------------------------------------------------
`ifndef VARIABLE_LENGTH_STRING_STACK_ASSERT_SVH
`define VARIABLE_LENGTH_STRING_STACK_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define VLSS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define VLSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

>>> rtl/core/vlss_pkg.sv
// ---------------------------------------------------------------------------
// String stack package
// Types and codes used by the string stack RTL.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package vlss_pkg;
   localparam logic [1:0] OP_PUSH = 2'd0;
   localparam logic [1:0] OP_POP  = 2'd1;
   localparam logic [1:0] OP_PEEK = 2'd2;
   localparam logic [1:0] OP_POPN = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_ROOM  = 2'd2;
   localparam logic [1:0] ST_LONG  = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE, S_POP_RD, S_POP_WT, S_POP_GO, S_SUM_RD, S_SUM_WT, S_SUM_ADD,
      S_BYTE_RD, S_BYTE_WT, S_BYTE_OUT, S_DROP_RD, S_DROP_WT, S_DROP_SUB, S_RESP
   } state_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       last;
      logic [3:0] out_meta;
      logic [1:0] status;
      logic [6:0] entries;
   } rsp_type;
endpackage

>>> rtl/core/vlss_ram.sv
// ---------------------------------------------------------------------------
// String stack memory
// Single port synchronous memory with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module vlss_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end
   assign rd_data = rd_data_ff;
endmodule

>>> rtl/core/variable_length_string_stack.sv
// ---------------------------------------------------------------------------
// Variable-length string stack
// Stack of byte strings packed in one byte memory, with an entry table.
// ---------------------------------------------------------------------------
// Usage: request words arrive on req_ with the op and the char_valid flag in
// req_tuser, the other fields in req_tdata and last_byte on req_tlast. Result
// words leave on rsp_ with byte_valid in rsp_tuser; the last word of each
// request has rsp_tlast set. The block takes one request at a time:
// req_tready is high only while the sequencer is idle. A push, a clear or a
// rejected request gives its status word from the response state through the
// output register. Pop and peek read the memories through one shared
// add/subtract unit: pop reads the top entry (read, wait, go states), peek
// reads each entry from the top down to and including the chosen one, then
// each string byte is streamed with one memory read per byte. Pop-many drops
// entries one at a time (read, wait, subtract states) and then sends its
// status word. A stalled receiver holds the output register and the
// sequencer waits in place. Reset clears the counters and the pending
// string; the memories need no clearing since only written places are ever
// read.
`timescale 1ns / 1ps
`include "variable_length_string_stack_assert.svh"
module variable_length_string_stack #(
   parameter int BYTE_DEPTH  = 1024,
   parameter int ENTRY_DEPTH = 64,
   parameter int MAX_STRING  = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // char_byte[7:0], push_meta[11:8], depth_index[17:12], with_barrier[18],
   // pop_count[25:19], zero fill
   input  logic [31:0] req_tdata,
   // op[1:0], char_valid[2]
   input  logic [2:0]  req_tuser,
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_byte[7:0], out_meta[11:8], status[13:12], entries[20:14], zero fill
   output logic [23:0] rsp_tdata,
   output logic        rsp_tuser,   // byte_valid
   output logic        rsp_tlast    // last
);
   import vlss_pkg::*;

   localparam int BA = $clog2(BYTE_DEPTH);
   localparam int EA = $clog2(ENTRY_DEPTH);
   localparam int BW = $clog2(BYTE_DEPTH + 1);
   localparam int CW = $clog2(ENTRY_DEPTH + 1);
   localparam int LW = 7;
   localparam int UW = (BW > CW ? BW : CW) + 1;

   logic [1:0] r_op;
   logic [7:0] r_byte;
   logic       r_cv;
   logic [3:0] r_meta;
   logic [5:0] r_idx;
   logic       r_bar;
   logic [6:0] r_cnt;
   assign r_op   = req_tuser[1:0];
   assign r_cv   = req_tuser[2];
   assign r_byte = req_tdata[7:0];
   assign r_meta = req_tdata[11:8];
   assign r_idx  = req_tdata[17:12];
   assign r_bar  = req_tdata[18];
   assign r_cnt  = req_tdata[25:19];

   state_type state_ff, state_in;
   logic [BW-1:0] used_ff, used_in;
   logic [CW-1:0] count_ff, count_in;
   logic [LW-1:0] pend_ff, pend_in;
   // Per-item working registers
   logic [BW-1:0] ptr_ff, ptr_in;      // byte address / end pointer
   logic [LW-1:0] left_ff, left_in;    // bytes left to stream
   logic [CW-1:0] ent_ff, ent_in;      // entry being read
   logic [CW-1:0] stop_ff, stop_in;    // target entry / pops left
   logic [3:0]    meta_ff, meta_in;
   logic          bar_ff, bar_in;
   logic [1:0]    st_ff, st_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rv_ff, rv_in;

   // Shared adder: one add or subtract per cycle
   logic [UW-1:0] add_a, add_b, add_y;
   logic          add_sub;
   assign add_y = add_sub ? add_a - add_b : add_a + add_b;

   logic          b_we, e_we;
   logic [BA-1:0] b_addr;
   logic [EA-1:0] e_addr;
   logic [7:0]    b_rd;
   logic [10:0]   e_rd, e_wd;

   vlss_ram #(.DEPTH(BYTE_DEPTH), .WIDTH(8)) u_bytes (
      .clock(clock), .wr_en(b_we), .addr(b_addr), .wr_data(r_byte), .rd_data(b_rd));
   vlss_ram #(.DEPTH(ENTRY_DEPTH), .WIDTH(11)) u_table (
      .clock(clock), .wr_en(e_we), .addr(e_addr), .wr_data(e_wd), .rd_data(e_rd));

   logic          out_free;
   logic [BW:0]   stage_ix;
   logic [BW:0]   fit_sum;
   logic [LW-1:0] plen;
   logic          too_long;
   assign out_free = !rv_ff || rsp_tready;
   assign stage_ix = (BW+1)'(used_ff) + (BW+1)'(pend_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
         count_ff <= '0;
         pend_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         rv_ff    <= rv_in;
      end
      ptr_ff  <= ptr_in;
      left_ff <= left_in;
      ent_ff  <= ent_in;
      stop_ff <= stop_in;
      meta_ff <= meta_in;
      bar_ff  <= bar_in;
      st_ff   <= st_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      state_in = state_ff;
      used_in  = used_ff;
      count_in = count_ff;
      pend_in  = pend_ff;
      ptr_in   = ptr_ff;
      left_in  = left_ff;
      ent_in   = ent_ff;
      stop_in  = stop_ff;
      meta_in  = meta_ff;
      bar_in   = bar_ff;
      st_in    = st_ff;
      rsp_in   = rsp_ff;
      rv_in    = rv_ff && !rsp_tready;
      req_tready = 1'b0;
      b_we = 1'b0;
      e_we = 1'b0;
      b_addr = BA'(stage_ix);
      e_addr = EA'(ent_ff);
      e_wd   = {r_meta, pend_ff};
      add_a = '0;
      add_b = '0;
      add_sub = 1'b0;
      plen = pend_ff;
      too_long = 1'b0;
      fit_sum = '0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               bar_in = r_bar;
               st_in  = ST_OK;
               case (r_op)
                  OP_PUSH: begin
                     if (r_cv) begin
                        if (32'(pend_ff) >= MAX_STRING) begin
                           plen = LW'(MAX_STRING + 1);
                           st_in = ST_LONG;
                        end else begin
                           b_we = stage_ix < (BW+1)'(BYTE_DEPTH);
                           plen = pend_ff + 1'b1;
                        end
                     end
                     too_long = 32'(plen) > MAX_STRING;
                     fit_sum  = (BW+1)'(used_ff) + (BW+1)'(plen);
                     pend_in  = plen;
                     if (req_tlast) begin
                        pend_in = '0;
                        e_addr  = EA'(count_ff);
                        e_wd    = {r_meta, plen};
                        if (too_long) begin
                           st_in = ST_LONG;
                        end else if (32'(count_ff) >= ENTRY_DEPTH ||
                                     fit_sum > (BW+1)'(BYTE_DEPTH)) begin
                           st_in = ST_ROOM;
                        end else begin
                           e_we = 1'b1;
                           count_in = count_ff + 1'b1;
                           used_in  = BW'(fit_sum);
                        end
                     end
                     state_in = S_RESP;
                  end
                  OP_POP: begin
                     pend_in = '0;
                     if (count_ff == '0) begin
                        st_in = ST_EMPTY;
                        state_in = S_RESP;
                     end else begin
                        ent_in = count_ff - 1'b1;
                        state_in = S_POP_RD;
                     end
                  end
                  OP_PEEK: begin
                     pend_in = '0;
                     if (32'(r_idx) >= 32'(count_ff)) begin
                        st_in = ST_EMPTY;
                        state_in = S_RESP;
                     end else begin
                        stop_in = CW'(32'(count_ff) - 1 - 32'(r_idx));
                        ent_in  = count_ff - 1'b1;
                        ptr_in  = used_ff;
                        state_in = S_SUM_RD;
                     end
                  end
                  default: begin
                     pend_in = '0;
                     if (r_cnt == '0) begin
                        count_in = '0;
                        used_in  = '0;
                        state_in = S_RESP;
                     end else if (count_ff == '0) begin
                        state_in = S_RESP;
                     end else begin
                        stop_in = (32'(r_cnt) > 32'(count_ff)) ? count_ff : CW'(r_cnt);
                        state_in = S_DROP_RD;
                     end
                  end
               endcase
            end
         end
         // Pop: read top entry, drop it, then stream from new bytes_used
         S_POP_RD: state_in = S_POP_WT;
         S_POP_WT: state_in = S_POP_GO;
         S_POP_GO: begin
            meta_in = bar_ff ? e_rd[10:7] : {1'b0, e_rd[9:7]};
            left_in = e_rd[6:0];
            add_a = UW'(used_ff);
            add_b = UW'(e_rd[6:0]);
            add_sub = 1'b1;
            ptr_in  = (UW'(used_ff) >= UW'(e_rd[6:0])) ? BW'(add_y) : '0;
            used_in = ptr_in;
            count_in = count_ff - 1'b1;
            state_in = S_BYTE_RD;
         end
         // Peek: walk entries from the top, subtracting lengths from the end
         S_SUM_RD: state_in = S_SUM_WT;
         S_SUM_WT: state_in = S_SUM_ADD;
         S_SUM_ADD: begin
            add_a = UW'(ptr_ff);
            add_b = UW'(e_rd[6:0]);
            add_sub = 1'b1;
            ptr_in = (UW'(ptr_ff) >= UW'(e_rd[6:0])) ? BW'(add_y) : '0;
            if (ent_ff == stop_ff) begin
               meta_in = bar_ff ? e_rd[10:7] : {1'b0, e_rd[9:7]};
               left_in = e_rd[6:0];
               state_in = S_BYTE_RD;
            end else begin
               ent_in = ent_ff - 1'b1;
               state_in = S_SUM_RD;
            end
         end
         // Stream bytes from ptr, one memory read each
         S_BYTE_RD: begin
            b_addr = BA'(ptr_ff);
            state_in = S_BYTE_WT;
         end
         S_BYTE_WT: begin
            b_addr = BA'(ptr_ff);
            state_in = S_BYTE_OUT;
         end
         S_BYTE_OUT: begin
            b_addr = BA'(ptr_ff);
            if (out_free) begin
               rv_in = 1'b1;
               rsp_in.out_byte   = (left_ff == '0) ? 8'd0 : b_rd;
               rsp_in.byte_valid = left_ff != '0;
               rsp_in.last       = left_ff <= LW'(1);
               rsp_in.out_meta   = meta_ff;
               rsp_in.status     = ST_OK;
               rsp_in.entries    = 7'(count_ff);
               add_a = UW'(ptr_ff);
               add_b = UW'(1);
               ptr_in = BW'(add_y);
               if (left_ff <= LW'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  left_in = left_ff - 1'b1;
                  state_in = S_BYTE_RD;
               end
            end
         end
         // Pop-many: drop the top entry per pass
         S_DROP_RD: begin
            e_addr = EA'(count_ff - 1'b1);
            state_in = S_DROP_WT;
         end
         S_DROP_WT: begin
            e_addr = EA'(count_ff - 1'b1);
            state_in = S_DROP_SUB;
         end
         S_DROP_SUB: begin
            add_a = UW'(used_ff);
            add_b = UW'(e_rd[6:0]);
            add_sub = 1'b1;
            used_in = (UW'(used_ff) >= UW'(e_rd[6:0])) ? BW'(add_y) : '0;
            count_in = count_ff - 1'b1;
            stop_in = stop_ff - 1'b1;
            state_in = (stop_ff == CW'(1)) ? S_RESP : S_DROP_RD;
         end
         S_RESP: begin
            if (out_free) begin
               rv_in = 1'b1;
               rsp_in.out_byte   = '0;
               rsp_in.byte_valid = 1'b0;
               rsp_in.last       = 1'b1;
               rsp_in.out_meta   = '0;
               rsp_in.status     = st_ff;
               rsp_in.entries    = 7'(count_ff);
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.entries, rsp_ff.status, rsp_ff.out_meta,
                        rsp_ff.out_byte};
   assign rsp_tuser  = rsp_ff.byte_valid;
   assign rsp_tlast  = rsp_ff.last;

   `VLSS_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable({rsp_tuser, rsp_tlast, rsp_tdata}), "stalled result word changed")
   `VLSS_ASSERT_IMP(a_count, clock, reset, 1'b1,
      32'(count_ff) <= ENTRY_DEPTH, "entry count above table depth")
   `VLSS_ASSERT_IMP(a_used, clock, reset, 1'b1,
      32'(used_ff) <= BYTE_DEPTH, "bytes used above store depth")
   `VLSS_ASSERT_IMP(a_pend, clock, reset, 1'b1,
      32'(pend_ff) <= MAX_STRING + 1, "pending length out of range")
endmodule
